>>> rtl/cel_pkg.sv
`default_nettype none

package cel_pkg;

    // operation codes carried on s_tuser
    typedef enum logic [2:0] {
        ACT_APPEND          = 3'd0,
        ACT_CLEAR           = 3'd1,
        ACT_OPEN_RECENT     = 3'd2,
        ACT_OPEN_UNNOTIFIED = 3'd3,
        ACT_NEXT            = 3'd4
    } act_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // read cursor direction
    localparam logic MODE_RECENT     = 1'b0;
    localparam logic MODE_UNNOTIFIED = 1'b1;

    // stream field layout
    localparam int ACTION_W  = 3;
    localparam int STAMP_W   = 32;
    localparam int KIND_W    = 8;
    localparam int PAYLOAD_W = 64;
    localparam int MAXR_W    = 6;
    localparam int COUNT_W   = 6;
    localparam int S_DATA_W  = 112;
    localparam int M_DATA_W  = 120;

    typedef struct packed {
        logic capture;
        logic execute;
    } cel_cmd_t;

    typedef struct packed {
        logic out_stall;
    } cel_stat_t;

endpackage

`default_nettype wire

>>> rtl/cel_ctrl.sv
`default_nettype none

module cel_ctrl
    import cel_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output cel_cmd_t       cmd,
    input  wire cel_stat_t stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold the transaction until the result register can take it
                if (!stat.out_stall)
                begin
                    cmd.execute = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/cel_datapath.sv
`default_nettype none

module cel_datapath
    import cel_pkg::*;
#(
    parameter int SLOTS        = 64,
    parameter int PAYLOAD_BITS = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cel_cmd_t              cmd,
    output cel_stat_t                  stat,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic [ACTION_W-1:0]   s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,
    output logic                       m_tuser
);

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int WIDE_W  = (IDX_W > MAXR_W) ? IDX_W : MAXR_W;
    localparam int ENTRY_W = STAMP_W + KIND_W + PAYLOAD_BITS;
    localparam logic [IDX_W:0]   SLOTS_X = (IDX_W + 1)'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == LAST_IDX)
        begin
            r = '0;
        end
        else
        begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == '0)
        begin
            r = LAST_IDX;
        end
        else
        begin
            r = i - 1'b1;
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] held_of(input logic [IDX_W-1:0] hd,
                                                  input logic [IDX_W-1:0] tl);
        logic [IDX_W:0] sum;
        if (hd >= tl)
        begin
            sum = {1'b0, hd} - {1'b0, tl};
        end
        else
        begin
            sum = {1'b0, hd} + SLOTS_X - {1'b0, tl};
        end
        return sum[IDX_W-1:0];
    endfunction

    // captured transaction
    logic [ACTION_W-1:0]     action_reg;
    logic [STAMP_W-1:0]      stamp_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [MAXR_W-1:0]       maxr_reg;

    // ring and cursor state
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] notified_reg, notified_next;
    logic             cur_valid_reg, cur_valid_next;
    logic             cur_mode_reg, cur_mode_next;
    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    logic [IDX_W-1:0] cur_rem_reg, cur_rem_next;

    // entry memory
    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;

    // result register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    logic             found;
    logic [IDX_W-1:0] held_now;
    logic [IDX_W-1:0] held_after;
    logic [IDX_W:0]   unnot_cnt;
    logic [STAMP_W-1:0]   rd_stamp;
    logic [KIND_W-1:0]    rd_kind;
    logic [PAYLOAD_W-1:0] rd_payload;

    assign stat.out_stall = m_tvalid_reg && !m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign rd_stamp   = rd_data_reg[STAMP_W-1:0];
    assign rd_kind    = rd_data_reg[STAMP_W +: KIND_W];
    assign rd_payload = PAYLOAD_W'(rd_data_reg[STAMP_W + KIND_W +: PAYLOAD_BITS]);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg  <= s_tuser;
            stamp_reg   <= s_tdata[STAMP_W-1:0];
            kind_reg    <= s_tdata[STAMP_W +: KIND_W];
            payload_reg <= s_tdata[STAMP_W + KIND_W +: PAYLOAD_BITS];
            maxr_reg    <= s_tdata[STAMP_W + KIND_W + PAYLOAD_W +: MAXR_W];
        end
    end

    // cursor entry is fetched while the transaction is captured
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_data_reg <= mem[cur_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {payload_reg, kind_reg, stamp_reg};
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        notified_next  = notified_reg;
        cur_valid_next = cur_valid_reg;
        cur_mode_next  = cur_mode_reg;
        cur_idx_next   = cur_idx_reg;
        cur_rem_next   = cur_rem_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        found          = 1'b0;
        held_now       = held_of(head_reg, tail_reg);

        if (head_reg > notified_reg)
        begin
            unnot_cnt = {1'b0, head_reg} - {1'b0, notified_reg} - 1'b1;
        end
        else
        begin
            unnot_cnt = {1'b0, head_reg} + SLOTS_X - {1'b0, notified_reg} - 1'b1;
        end

        if (cmd.execute)
        begin
            unique case (action_reg)
                ACT_APPEND:
                begin
                    wr_en          = 1'b1;
                    head_next      = idx_inc(head_reg);
                    if (idx_inc(head_reg) == tail_reg)
                    begin
                        tail_next = idx_inc(tail_reg);
                    end
                    cur_valid_next = 1'b0;
                end
                ACT_CLEAR:
                begin
                    wr_en          = 1'b1;
                    wr_addr        = '0;
                    head_next      = idx_inc('0);
                    tail_next      = '0;
                    notified_next  = LAST_IDX;
                    cur_valid_next = 1'b0;
                end
                ACT_OPEN_RECENT:
                begin
                    cur_mode_next  = MODE_RECENT;
                    if (maxr_reg == '0 || WIDE_W'(maxr_reg) > WIDE_W'(held_now))
                    begin
                        cur_rem_next = held_now;
                    end
                    else
                    begin
                        cur_rem_next = IDX_W'(maxr_reg);
                    end
                    cur_idx_next   = idx_dec(head_reg);
                    cur_valid_next = 1'b1;
                end
                ACT_OPEN_UNNOTIFIED:
                begin
                    cur_mode_next  = MODE_UNNOTIFIED;
                    cur_rem_next   = unnot_cnt[IDX_W-1:0];
                    cur_idx_next   = idx_inc(notified_reg);
                    cur_valid_next = 1'b1;
                end
                ACT_NEXT:
                begin
                    if (cur_valid_reg && cur_rem_reg != '0)
                    begin
                        found        = 1'b1;
                        cur_rem_next = cur_rem_reg - 1'b1;
                        if (cur_mode_reg == MODE_RECENT)
                        begin
                            cur_idx_next = idx_dec(cur_idx_reg);
                        end
                        else
                        begin
                            notified_next = cur_idx_reg;
                            cur_idx_next  = idx_inc(cur_idx_reg);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        held_after = held_of(head_next, tail_next);
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (cmd.execute)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = found;
            m_tdata_next  = '0;
            if (found)
            begin
                m_tdata_next[STAMP_W-1:0]                 = rd_stamp;
                m_tdata_next[STAMP_W +: KIND_W]           = rd_kind;
                m_tdata_next[STAMP_W + KIND_W +: PAYLOAD_W] = rd_payload;
            end
            // count field keeps the low bits of the held count
            m_tdata_next[STAMP_W + KIND_W + PAYLOAD_W +: COUNT_W] =
                COUNT_W'(WIDE_W'(held_after));
            if (cur_valid_next)
            begin
                m_tdata_next[STAMP_W + KIND_W + PAYLOAD_W + COUNT_W +: COUNT_W] =
                    COUNT_W'(WIDE_W'(cur_rem_next));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            notified_reg  <= LAST_IDX;
            cur_valid_reg <= 1'b0;
            cur_mode_reg  <= MODE_RECENT;
            cur_idx_reg   <= '0;
            cur_rem_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            notified_reg  <= notified_next;
            cur_valid_reg <= cur_valid_next;
            cur_mode_reg  <= cur_mode_next;
            cur_idx_reg   <= cur_idx_next;
            cur_rem_reg   <= cur_rem_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

`default_nettype wire

>>> rtl/circular_event_log.sv
// channel | dir | tdata (low bit up)                                   | tuser
// --------+-----+------------------------------------------------------+--------
// s_      | in  | stamp, entry_kind, payload, max_results, pad to 112  | action
// m_      | out | out_stamp, out_kind, out_payload, held_count,        | found
//         |     | left_to_read, pad to 120                             |
//
// a transaction is handled in S_IDLE, which captures it and reads the cursor
// entry from the synchronous entry memory, then in S_EXEC, which updates the ring
// and cursor pointers and loads the result register
// the next input is taken as soon as the result is loaded, even while it
// still waits on m_tready; a stalled result holds the block in S_EXEC
// reset clears pointers, cursor and result valid only; the entry memory has no
// clearing pass and an entry is meaningful once it has been written
`default_nettype none

module circular_event_log
    import cel_pkg::*;
#(
    parameter int SLOTS        = 64,
    parameter int PAYLOAD_BITS = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // stamp[31:0], entry_kind[39:32], payload[103:40], max_results[109:104]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // action[2:0]
    input  wire logic [ACTION_W-1:0] s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // out_stamp[31:0], out_kind[39:32], out_payload[103:40],
    // held_count[109:104], left_to_read[115:110]
    output logic [M_DATA_W-1:0]      m_tdata,
    // found
    output logic                     m_tuser
);

    cel_cmd_t  cmd;
    cel_stat_t stat;

    // sequencing: capture then execute, waiting on the result register
    cel_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // entry memory, ring pointers, read cursor and result register
    cel_datapath #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // a captured transaction is never executed in the same cycle
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute together");

    // after a transaction is taken the input side closes while it is executed
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in flight");

    // every executed transaction shows up on the output side
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> m_tvalid)
        else $error("executed transaction produced no result");

    // execution only happens when the result register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> !(m_tvalid && !m_tready))
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire
